>>> hw/rtl/fsp_pkg.sv
// Shared types and constants of the FLV tag stream parser.
package fsp_pkg;

    // Kind of record handed to the output side.
    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_TAG    = 2'd1,
        REC_ERROR  = 2'd2
    } rec_kind_t;

    // Tag type codes (low five bits of the tag type byte).
    localparam logic [4:0] KIND_AUDIO  = 5'd8;
    localparam logic [4:0] KIND_VIDEO  = 5'd9;
    localparam logic [4:0] KIND_SCRIPT = 5'd18;

    // File signature "FLV".
    localparam logic [23:0] FLV_SIGNATURE = 24'h464c56;

    // Mask for the tag type field.
    localparam logic [7:0] TAG_KIND_MASK = 8'h1f;

    // Width of the packed result item and its tuser.
    localparam int unsigned OUT_DATA_W = 208;
    localparam int unsigned OUT_USER_W = 2;

    // One queued record. For a file header, body[71:0] holds header bytes 0..8
    // with byte 0 highest; for a tag, body holds the 11 tag header bytes.
    typedef struct packed {
        rec_kind_t    kind;
        logic [31:0]  tag_number;
        logic [87:0]  body;
        logic [31:0]  prev_size;
        logic [15:0]  desc;
    } rec_entry_t;

endpackage

>>> hw/rtl/fsp_front.sv
// Front end: accepts file bytes, tracks the parse phase and queues records.
module fsp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_accept,
    input  logic [7:0]         data_byte,
    input  logic               file_start,
    output logic               rec_push,
    output fsp_pkg::rec_entry_t rec_entry
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PREV,
        PH_TAGHDR,
        PH_DESC,
        PH_SKIP,
        PH_IDLE
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [23:0]  count_reg, count_next;
    logic [63:0]  hshift_reg, hshift_next;
    logic [31:0]  prev_reg, prev_next;
    logic [87:0]  taghdr_reg, taghdr_next;
    logic [15:0]  desc_reg, desc_next;
    logic [31:0]  tagcnt_reg, tagcnt_next;

    phase_t       cur_phase;
    logic [23:0]  cur_count;
    logic [31:0]  cur_tagcnt;
    logic [87:0]  taghdr_shift;
    logic [4:0]   kind_now;
    logic [23:0]  size_now;
    logic [1:0]   need_now;
    logic [23:0]  rest_now;
    logic [23:0]  count_inc;

    // Number of descriptor bytes to read, limited by the payload size.
    function automatic logic [1:0] desc_need(input logic [4:0] kind, input logic [23:0] size);
        logic [1:0] want;
        begin
            if (kind == fsp_pkg::KIND_AUDIO)
            begin
                want = 2'd2;
            end
            else if (kind == fsp_pkg::KIND_VIDEO || kind == fsp_pkg::KIND_SCRIPT)
            begin
                want = 2'd1;
            end
            else
            begin
                want = 2'd0;
            end
            if (size < {22'd0, want})
            begin
                desc_need = size[1:0];
            end
            else
            begin
                desc_need = want;
            end
        end
    endfunction

    // A set file_start flag restarts the parse on this very item.
    assign cur_phase  = file_start ? PH_HEADER : phase_reg;
    assign cur_count  = file_start ? 24'd0 : count_reg;
    assign cur_tagcnt = file_start ? 32'd0 : tagcnt_reg;
    assign count_inc  = cur_count + 24'd1;

    // Tag header fields as seen after this item has been stored.
    assign taghdr_shift = {taghdr_reg[79:0], data_byte};
    assign kind_now = (cur_phase == PH_TAGHDR) ? taghdr_shift[84:80] : taghdr_reg[84:80];
    assign size_now = (cur_phase == PH_TAGHDR) ? taghdr_shift[79:56] : taghdr_reg[79:56];
    assign need_now = desc_need(kind_now, size_now);
    assign rest_now = size_now - {22'd0, need_now};

    // Next-state and record logic.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        hshift_next = hshift_reg;
        prev_next   = prev_reg;
        taghdr_next = taghdr_reg;
        desc_next   = desc_reg;
        tagcnt_next = tagcnt_reg;
        rec_push    = 1'b0;
        rec_entry.kind       = fsp_pkg::REC_TAG;
        rec_entry.tag_number = cur_tagcnt;
        rec_entry.body       = taghdr_reg;
        rec_entry.prev_size  = prev_reg;
        rec_entry.desc       = desc_reg;
        if (byte_accept)
        begin
            phase_next  = cur_phase;
            count_next  = cur_count;
            tagcnt_next = cur_tagcnt;
            unique case (cur_phase)
                PH_HEADER:
                begin
                    if (cur_count < 24'd8)
                    begin
                        hshift_next = {hshift_reg[55:0], data_byte};
                        count_next  = count_inc;
                    end
                    else
                    begin
                        count_next     = 24'd0;
                        rec_push       = 1'b1;
                        rec_entry.body = {16'd0, hshift_reg, data_byte};
                        if (hshift_reg[63:40] != fsp_pkg::FLV_SIGNATURE)
                        begin
                            rec_entry.kind = fsp_pkg::REC_ERROR;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            rec_entry.kind = fsp_pkg::REC_HEADER;
                            phase_next     = PH_PREV;
                        end
                    end
                end
                PH_PREV:
                begin
                    prev_next = {prev_reg[23:0], data_byte};
                    if (cur_count == 24'd3)
                    begin
                        count_next = 24'd0;
                        phase_next = PH_TAGHDR;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_TAGHDR:
                begin
                    taghdr_next = taghdr_shift;
                    if (cur_count == 24'd10)
                    begin
                        count_next = 24'd0;
                        desc_next  = 16'd0;
                        if (need_now == 2'd0)
                        begin
                            rec_push       = 1'b1;
                            rec_entry.body = taghdr_next;
                            rec_entry.desc = desc_next;
                            if (size_now == 24'd0)
                            begin
                                phase_next = PH_PREV;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                                count_next = size_now;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DESC;
                        end
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_DESC:
                begin
                    if (kind_now == fsp_pkg::KIND_AUDIO)
                    begin
                        if (cur_count == 24'd0)
                        begin
                            desc_next = {data_byte, 8'd0};
                        end
                        else
                        begin
                            desc_next = desc_reg | {8'd0, data_byte};
                        end
                    end
                    else if (kind_now == fsp_pkg::KIND_VIDEO)
                    begin
                        desc_next = {data_byte, 8'd0};
                    end
                    else
                    begin
                        desc_next = {8'd0, data_byte};
                    end
                    count_next = count_inc;
                    if (count_inc >= {22'd0, need_now})
                    begin
                        rec_push       = 1'b1;
                        rec_entry.desc = desc_next;
                        if (rest_now == 24'd0)
                        begin
                            phase_next = PH_PREV;
                            count_next = 24'd0;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                            count_next = rest_now;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (cur_count <= 24'd1)
                    begin
                        count_next = 24'd0;
                        phase_next = PH_PREV;
                    end
                    else
                    begin
                        count_next = cur_count - 24'd1;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            // Saturating count of tags in this file.
            if (rec_push && rec_entry.kind == fsp_pkg::REC_TAG && cur_tagcnt != 32'hffffffff)
            begin
                tagcnt_next = cur_tagcnt + 32'd1;
            end
        end
    end

    // Parse state and field registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 24'd0;
            tagcnt_reg <= 32'd0;
            hshift_reg <= 64'd0;
            prev_reg   <= 32'd0;
            taghdr_reg <= 88'd0;
            desc_reg   <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            tagcnt_reg <= tagcnt_next;
            hshift_reg <= hshift_next;
            prev_reg   <= prev_next;
            taghdr_reg <= taghdr_next;
            desc_reg   <= desc_next;
        end
    end

endmodule

>>> hw/rtl/fsp_queue.sv
// Short record queue between the parser front end and the output stage.
module fsp_queue #(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fsp_pkg::rec_entry_t push_entry,
    input  logic                pop,
    output fsp_pkg::rec_entry_t head_entry,
    output logic                empty,
    output logic                full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fsp_pkg::rec_entry_t store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic                do_push, do_pop;

    assign empty      = (fill_reg == CNT_W'(0));
    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = store_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/fsp_back.sv
// Back end: formats queued records into result items and holds the output register.
module fsp_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fsp_pkg::rec_entry_t                  head_entry,
    input  logic                                 empty,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fsp_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [fsp_pkg::OUT_USER_W-1:0]       m_tuser
);

    logic                               valid_reg, valid_next;
    logic [fsp_pkg::OUT_DATA_W-1:0]     data_reg, data_fmt;
    logic [fsp_pkg::OUT_USER_W-1:0]     user_reg;

    assign pop        = !empty && (!valid_reg || m_tready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !m_tready);

    // Pack the record fields by kind; fields of other kinds stay zero.
    always_comb
    begin
        data_fmt = '0;
        case (head_entry.kind)
            fsp_pkg::REC_HEADER:
            begin
                data_fmt[7:0]   = head_entry.body[47:40];
                data_fmt[9:8]   = {head_entry.body[34], head_entry.body[32]};
                data_fmt[41:10] = head_entry.body[31:0];
            end
            fsp_pkg::REC_TAG:
            begin
                data_fmt[73:42]   = head_entry.tag_number;
                data_fmt[78:74]   = head_entry.body[84:80];
                data_fmt[102:79]  = head_entry.body[79:56];
                data_fmt[126:103] = head_entry.body[55:32];
                data_fmt[134:127] = head_entry.body[31:24];
                data_fmt[158:135] = head_entry.body[23:0];
                data_fmt[190:159] = head_entry.prev_size;
                data_fmt[206:191] = head_entry.desc;
            end
            default:
            begin
                data_fmt = '0;
            end
        endcase
    end

    // Output handshake flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_fmt;
            user_reg <= head_entry.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

>>> hw/rtl/flv_tag_stream_parser_unit.sv
// Top level of the FLV tag stream parser.
// The input stream carries the FLV file one byte per item: s_tdata holds the
// byte and s_tuser marks the first byte of a new file, which restarts parsing
// and clears the tag counter. The output stream carries one record per file
// header, per tag, or per bad signature; m_tuser gives the record kind and
// m_tdata the packed fields.
// The block takes one byte per cycle for as long as the record queue has
// room. A record enters the queue when the byte that completes it is
// accepted, then moves to the output register. The parser runs ahead of
// the output register by up to QUEUE_DEPTH records, so a stalled receiver
// only holds s_tready low once the queue has filled; records are never dropped.
// After reset the parser waits for the file header and the output is empty.
// A file with a bad signature yields one error record, then bytes are dropped
// until the next item with the file start flag set.
module flv_tag_stream_parser_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // data_byte[7:0]
    input  logic           s_tuser,   // file_start
    output logic           m_tvalid,
    input  logic           m_tready,
    // version[7:0], av_flags[9:8], header_offset[41:10], tag_number[73:42],
    // tag_kind[78:74], payload_size[102:79], time_stamp[126:103],
    // time_stamp_ext[134:127], stream_number[158:135], previous_size[190:159],
    // media_desc[206:191], zero pad[207]
    output logic [207:0]   m_tdata,
    output logic [1:0]     m_tuser    // record_kind[1:0]
);

    logic                 byte_accept;
    logic                 rec_push;
    fsp_pkg::rec_entry_t  rec_entry;
    fsp_pkg::rec_entry_t  head_entry;
    logic                 q_empty;
    logic                 q_full;
    logic                 q_pop;

    assign s_tready    = !q_full;
    assign byte_accept = s_tvalid && s_tready;

    // Parser front end.
    fsp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (s_tdata),
        .file_start  (s_tuser),
        .rec_push    (rec_push),
        .rec_entry   (rec_entry)
    );

    // Record queue.
    fsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_entry (rec_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Output formatter and register.
    fsp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .empty      (q_empty),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
